// File: hw/rtl/json_string_unescape_utf8_unit_defines.svh
// assertion macros for the json string unescape unit
// they sample on clk and are disabled while arst_n is low
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg)
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

	localparam int JSU_FIFO_DEPTH = 4;
	localparam int JSU_MAX_RES    = 3;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_STR,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NO_QUOTE = 2'd1;
	localparam logic [1:0] ERR_ESCAPE   = 2'd2;
	localparam logic [1:0] ERR_HEX      = 2'd3;

	localparam logic [7:0] CHR_QUOTE  = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5c;
	localparam logic [7:0] CHR_SLASH  = 8'h2f;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_TAB    = 8'h09;
	localparam logic [7:0] CHR_CR     = 8'h0d;
	localparam logic [7:0] CHR_LF     = 8'h0a;
	localparam logic [7:0] CHR_FF     = 8'h0c;
	localparam logic [7:0] CHR_BS     = 8'h08;
	localparam logic [7:0] CHR_LC_B   = 8'h62;
	localparam logic [7:0] CHR_LC_F   = 8'h66;
	localparam logic [7:0] CHR_LC_N   = 8'h6e;
	localparam logic [7:0] CHR_LC_R   = 8'h72;
	localparam logic [7:0] CHR_LC_T   = 8'h74;
	localparam logic [7:0] CHR_LC_U   = 8'h75;
	localparam logic [7:0] CHR_DIG_0  = 8'h30;
	localparam logic [7:0] CHR_DIG_9  = 8'h39;
	localparam logic [7:0] CHR_LC_A   = 8'h61;
	localparam logic [7:0] CHR_UC_A   = 8'h41;
	localparam logic [7:0] CHR_UC_F   = 8'h46;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic [1:0] err;
		logic       last;
	} res_t;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CHR_DIG_0 && c <= CHR_DIG_9) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CHR_LC_A && c <= CHR_LC_F) || (c >= CHR_UC_A && c <= CHR_UC_F)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// single-byte escapes, {valid, byte}
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			CHR_QUOTE, CHR_BSLASH, CHR_SLASH: r = {1'b1, c};
			CHR_LC_B: r = {1'b1, CHR_BS};
			CHR_LC_F: r = {1'b1, CHR_FF};
			CHR_LC_N: r = {1'b1, CHR_LF};
			CHR_LC_R: r = {1'b1, CHR_CR};
			CHR_LC_T: r = {1'b1, CHR_TAB};
			default:  r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/json_string_unescape_utf8_unit.sv
`timescale 1ns / 1ps
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_stall, in_byte               | in
// output   | out_valid, out_stall, out_byte, kind,     | out
//          | error_code, last                          |
//
// each byte is decoded in the cycle it is taken and its 0 to 3 results land in a
// result queue of DEPTH entries; while out_stall is low, one result leaves per cycle
// from the queue head; a byte is taken every cycle while at most DEPTH-3 results are
// queued, so plain text flows at one byte per cycle while out_stall is low
// in_stall comes from the queue fill register only, with no path from out_stall
// arst_n clears the decoder state and empties the queue

`include "json_string_unescape_utf8_unit_defines.svh"

module json_string_unescape_utf8_unit import jsu_pkg::*; #(
	parameter int DEPTH = JSU_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic [1:0] error_code,
	output logic       last
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [11:0] cp_q, cp_d;

	logic        acc;
	logic        pop;
	logic [4:0]  hex;
	logic [8:0]  esc;
	logic [15:0] cp_full;
	logic [1:0]  res_n;
	res_t        res [JSU_MAX_RES];

	res_t          fifo_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] wr_idx [JSU_MAX_RES];
	logic [PW:0]   wr_sum [JSU_MAX_RES];
	logic [PW:0]   wr_next;
	logic [PW:0]   rd_next;

	assign acc     = in_valid && !in_stall;
	assign pop     = out_valid && !out_stall;
	assign hex     = hex_digit(in_byte);
	assign esc     = esc_map(in_byte);
	assign cp_full = {cp_q, hex[3:0]};

	// next state
	always_comb begin
		mode_d    = mode_q;
		hex_cnt_d = hex_cnt_q;
		cp_d      = cp_q;
		unique case (mode_q)
			MODE_IDLE: begin
				if (in_byte == CHR_QUOTE) mode_d = MODE_STR;
			end
			MODE_STR: begin
				if (in_byte == CHR_BSLASH) mode_d = MODE_ESC;
				else if (in_byte == CHR_QUOTE) mode_d = MODE_IDLE;
			end
			MODE_ESC: begin
				if (in_byte == CHR_LC_U) begin
					mode_d    = MODE_HEX;
					hex_cnt_d = '0;
					cp_d      = '0;
				end else if (esc[8]) begin
					mode_d = MODE_STR;
				end else begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_HEX: begin
				if (!hex[4]) begin
					mode_d    = MODE_IDLE;
					hex_cnt_d = '0;
					cp_d      = '0;
				end else if (hex_cnt_q == 2'd3) begin
					mode_d    = MODE_STR;
					hex_cnt_d = '0;
					cp_d      = '0;
				end else begin
					hex_cnt_d = hex_cnt_q + 2'd1;
					cp_d      = {cp_q[7:0], hex[3:0]};
				end
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

	// results of the current byte
	always_comb begin
		res_n = 2'd0;
		for (int i = 0; i < JSU_MAX_RES; i++) res[i] = '0;
		unique case (mode_q)
			MODE_IDLE: begin
				if (!(in_byte == CHR_SPACE || in_byte == CHR_TAB || in_byte == CHR_CR ||
					in_byte == CHR_LF || in_byte == CHR_QUOTE)) begin
					res[0].kind = KIND_ERROR;
					res[0].err  = ERR_NO_QUOTE;
					res_n       = 2'd1;
				end
			end
			MODE_STR: begin
				if (in_byte == CHR_QUOTE) begin
					res[0].kind = KIND_END;
					res_n       = 2'd1;
				end else if (in_byte != CHR_BSLASH) begin
					res[0].data = in_byte;
					res_n       = 2'd1;
				end
			end
			MODE_ESC: begin
				if (esc[8]) begin
					res[0].data = esc[7:0];
					res_n       = 2'd1;
				end else if (in_byte != CHR_LC_U) begin
					res[0].kind = KIND_ERROR;
					res[0].err  = ERR_ESCAPE;
					res_n       = 2'd1;
				end
			end
			MODE_HEX: begin
				if (!hex[4]) begin
					res[0].kind = KIND_ERROR;
					res[0].err  = ERR_HEX;
					res_n       = 2'd1;
				end else if (hex_cnt_q == 2'd3) begin
					if (cp_full[15:7] == '0) begin
						res[0].data = {1'b0, cp_full[6:0]};
						res_n       = 2'd1;
					end else if (cp_full[15:11] == '0) begin
						res[0].data = {3'b110, cp_full[10:6]};
						res[1].data = {2'b10, cp_full[5:0]};
						res_n       = 2'd2;
					end else begin
						res[0].data = {4'b1110, cp_full[15:12]};
						res[1].data = {2'b10, cp_full[11:6]};
						res[2].data = {2'b10, cp_full[5:0]};
						res_n       = 2'd3;
					end
				end
			end
			default: res_n = 2'd0;
		endcase
		for (int i = 0; i < JSU_MAX_RES; i++) begin
			res[i].last = (res_n == 2'(i + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			hex_cnt_q <= '0;
			cp_q      <= '0;
		end else if (acc) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			cp_q      <= cp_d;
		end
	end

	// result queue, wrap handled by one compare since DEPTH >= 3
	always_comb begin
		for (int i = 0; i < JSU_MAX_RES; i++) begin
			wr_sum[i] = {1'b0, wr_ptr_q} + (PW + 1)'(i);
			if (wr_sum[i] >= (PW + 1)'(DEPTH)) wr_sum[i] = wr_sum[i] - (PW + 1)'(DEPTH);
			wr_idx[i] = wr_sum[i][PW-1:0];
		end
		wr_next = {1'b0, wr_ptr_q} + (PW + 1)'(res_n);
		if (wr_next >= (PW + 1)'(DEPTH)) wr_next = wr_next - (PW + 1)'(DEPTH);
		rd_next = {1'b0, rd_ptr_q} + (PW + 1)'(1);
		if (rd_next >= (PW + 1)'(DEPTH)) rd_next = rd_next - (PW + 1)'(DEPTH);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < JSU_MAX_RES; i++) begin
			if (acc && (2'(i) < res_n)) fifo_q[wr_idx[i]] <= res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (acc) wr_ptr_q <= wr_next[PW-1:0];
			if (pop) rd_ptr_q <= rd_next[PW-1:0];
			cnt_q <= cnt_q + (acc ? CW'(res_n) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	assign in_stall   = cnt_q > CW'(DEPTH - JSU_MAX_RES);
	assign out_valid  = cnt_q != '0;
	assign out_byte   = fifo_q[rd_ptr_q].data;
	assign kind       = fifo_q[rd_ptr_q].kind;
	assign error_code = fifo_q[rd_ptr_q].err;
	assign last       = fifo_q[rd_ptr_q].last;

	`JSU_ASSERT_IMPL(a_fill_bound, 1'b1, cnt_q <= CW'(DEPTH), "result queue overfilled")
	`JSU_ASSERT_IMPL(a_end_err_last, out_valid && kind != KIND_BYTE, last && out_byte == '0, "end or error not a lone result")
	`JSU_ASSERT_IMPL(a_hex_mode, hex_cnt_q != '0, mode_q == MODE_HEX, "hex count outside hex mode")
	`JSU_ASSERT_NEXT(a_open_quote, acc && mode_q == MODE_IDLE && in_byte == CHR_QUOTE, mode_q == MODE_STR, "opening quote not taken")

endmodule

// File: sim/json_string_unescape_utf8_unit_checker.sv
`timescale 1ns / 1ps

module json_string_unescape_utf8_unit_checker import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic [1:0] kind,
	input  logic [1:0] error_code,
	input  logic       last,
	output int         mismatches,
	output int         outstanding
);

	mode_t       scan_mode;
	logic [2:0]  digits_seen;
	logic [15:0] code_acc;
	res_t        decoded_expected[$];

	function automatic res_t make_res(input logic [7:0] d, input logic [1:0] k,
		input logic [1:0] e);
		res_t r;
		r.data = d;
		r.kind = k;
		r.err  = e;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic int nibble_value(input logic [7:0] c);
		if (c >= CHR_DIG_0 && c <= CHR_DIG_9) return int'(c - CHR_DIG_0);
		if (c >= CHR_LC_A && c <= CHR_LC_F) return int'(c - CHR_LC_A) + 10;
		if (c >= CHR_UC_A && c <= CHR_UC_F) return int'(c - CHR_UC_A) + 10;
		return -1;
	endfunction

	// works out the results of one text byte and queues them
	task automatic decode_text_byte(input logic [7:0] c);
		res_t batch[$];
		int   nib;
		case (scan_mode)
			MODE_IDLE: begin
				if (c == CHR_SPACE || c == CHR_TAB || c == CHR_CR || c == CHR_LF) begin
					// whitespace before the string is skipped
				end else if (c == CHR_QUOTE) begin
					scan_mode = MODE_STR;
				end else begin
					batch.push_back(make_res(8'h00, KIND_ERROR, ERR_NO_QUOTE));
				end
			end
			MODE_STR: begin
				if (c == CHR_BSLASH) begin
					scan_mode = MODE_ESC;
				end else if (c == CHR_QUOTE) begin
					scan_mode = MODE_IDLE;
					batch.push_back(make_res(8'h00, KIND_END, ERR_NONE));
				end else begin
					batch.push_back(make_res(c, KIND_BYTE, ERR_NONE));
				end
			end
			MODE_ESC: begin
				scan_mode = MODE_STR;
				case (c)
					CHR_QUOTE, CHR_BSLASH, CHR_SLASH: batch.push_back(make_res(c, KIND_BYTE, ERR_NONE));
					CHR_LC_B: batch.push_back(make_res(CHR_BS, KIND_BYTE, ERR_NONE));
					CHR_LC_F: batch.push_back(make_res(CHR_FF, KIND_BYTE, ERR_NONE));
					CHR_LC_N: batch.push_back(make_res(CHR_LF, KIND_BYTE, ERR_NONE));
					CHR_LC_R: batch.push_back(make_res(CHR_CR, KIND_BYTE, ERR_NONE));
					CHR_LC_T: batch.push_back(make_res(CHR_TAB, KIND_BYTE, ERR_NONE));
					CHR_LC_U: begin
						scan_mode   = MODE_HEX;
						digits_seen = '0;
						code_acc    = '0;
					end
					default: begin
						scan_mode = MODE_IDLE;
						batch.push_back(make_res(8'h00, KIND_ERROR, ERR_ESCAPE));
					end
				endcase
			end
			MODE_HEX: begin
				nib = nibble_value(c);
				if (nib < 0) begin
					// partial code point is thrown away
					scan_mode   = MODE_IDLE;
					digits_seen = '0;
					code_acc    = '0;
					batch.push_back(make_res(8'h00, KIND_ERROR, ERR_HEX));
				end else begin
					code_acc    = {code_acc[11:0], nib[3:0]};
					digits_seen = digits_seen + 3'd1;
					if (digits_seen == 3'd4) begin
						if (code_acc < 16'h0080) begin
							batch.push_back(make_res(code_acc[7:0], KIND_BYTE, ERR_NONE));
						end else if (code_acc < 16'h0800) begin
							batch.push_back(make_res({3'b110, code_acc[10:6]}, KIND_BYTE, ERR_NONE));
							batch.push_back(make_res({2'b10, code_acc[5:0]}, KIND_BYTE, ERR_NONE));
						end else begin
							batch.push_back(make_res({4'b1110, code_acc[15:12]}, KIND_BYTE, ERR_NONE));
							batch.push_back(make_res({2'b10, code_acc[11:6]}, KIND_BYTE, ERR_NONE));
							batch.push_back(make_res({2'b10, code_acc[5:0]}, KIND_BYTE, ERR_NONE));
						end
						scan_mode   = MODE_STR;
						digits_seen = '0;
						code_acc    = '0;
					end
				end
			end
		endcase
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) decoded_expected.push_back(batch[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int   bad;
		if (!arst_n) begin
			scan_mode   = MODE_IDLE;
			digits_seen = '0;
			code_acc    = '0;
			decoded_expected.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall) decode_text_byte(in_byte);
			if (out_valid && !out_stall) begin
				if (decoded_expected.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, got out_byte %02h kind %0d error_code %0d last %b",
						$time, out_byte, kind, error_code, last);
					mismatches <= mismatches + 1;
				end else begin
					want = decoded_expected.pop_front();
					bad  = 0;
					if (want.data !== out_byte) begin
						$display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte);
						bad++;
					end
					if (want.kind !== kind) begin
						$display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
						bad++;
					end
					if (want.err !== error_code) begin
						$display("%0t: error_code expected %0d got %0d", $time, want.err, error_code);
						bad++;
					end
					if (want.last !== last) begin
						$display("%0t: last expected %b got %b", $time, want.last, last);
						bad++;
					end
					if (bad != 0) mismatches <= mismatches + 1;
				end
			end
			outstanding <= decoded_expected.size();
		end
	end

endmodule

// File: sim/json_string_unescape_utf8_unit_tb.sv
`timescale 1ns / 1ps

module json_string_unescape_utf8_unit_tb;
	import jsu_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [1:0] error_code;
	logic       last;
	int         mismatches;
	int         outstanding;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int fed_items      = 0;

	int          src_idle_by_phase[5]  = '{0, 82, 0, 35, 0};
	int          sink_stall_by_phase[5] = '{0, 0, 82, 35, 0};
	logic [7:0]  esc_letters[8] = '{CHR_QUOTE, CHR_BSLASH, CHR_SLASH, CHR_LC_B,
		CHR_LC_F, CHR_LC_N, CHR_LC_R, CHR_LC_T};
	logic [15:0] boundary_points[7] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
		16'h0800, 16'hd800, 16'hffff};

	json_string_unescape_utf8_unit dut (.*);

	json_string_unescape_utf8_unit_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < sink_stall_pct);
	end

	task automatic feed_byte(input logic [7:0] b, input bit counts = 1'b1);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk iff !in_stall);
		if (counts) fed_items++;
	endtask

	task automatic feed_chars(input string s);
		for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk iff outstanding == 0);
	endtask

	function automatic logic [7:0] blank_byte();
		case ($urandom_range(0, 3))
			0: return CHR_SPACE;
			1: return CHR_TAB;
			2: return CHR_CR;
			default: return CHR_LF;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return CHR_DIG_0 + {4'd0, v};
		return ($urandom_range(0, 1) ? CHR_UC_A : CHR_LC_A) + {4'd0, v} - 8'd10;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CHR_QUOTE || b == CHR_BSLASH) b ^= 8'h80;
		return b;
	endfunction

	task automatic feed_unicode_escape();
		logic [15:0] cp;
		case ($urandom_range(0, 9))
			0, 1, 2: cp = 16'($urandom_range(16'h0000, 16'h007f));
			3, 4, 5: cp = 16'($urandom_range(16'h0080, 16'h07ff));
			6, 7, 8: cp = 16'($urandom_range(16'h0800, 16'hffff));
			default: cp = boundary_points[$urandom_range(0, 6)];
		endcase
		feed_byte(CHR_BSLASH);
		feed_byte(CHR_LC_U);
		feed_byte(hex_char(cp[15:12]));
		feed_byte(hex_char(cp[11:8]));
		feed_byte(hex_char(cp[7:4]));
		feed_byte(hex_char(cp[3:0]));
	endtask

	// mostly well-formed strings; a broken escape leaves the block idle, so no closing quote
	task automatic feed_random_text();
		int         len;
		int         pick;
		logic [7:0] b;
		repeat ($urandom_range(0, 2)) feed_byte(blank_byte(), 1'b0);
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom_range(0, 255));
				if (b == CHR_QUOTE) b ^= 8'h80;
				feed_byte(b);
			end
			return;
		end
		feed_byte(CHR_QUOTE);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
		repeat (len) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				feed_byte(plain_byte());
			end else if (pick < 78) begin
				feed_byte(CHR_BSLASH);
				feed_byte(esc_letters[$urandom_range(0, 7)]);
			end else if (pick < 95) begin
				feed_unicode_escape();
			end else if ($urandom_range(0, 1)) begin
				b = 8'($urandom_range(0, 255));
				if (b inside {CHR_QUOTE, CHR_BSLASH, CHR_SLASH, CHR_LC_B, CHR_LC_F, CHR_LC_N,
					CHR_LC_R, CHR_LC_T, CHR_LC_U}) b ^= 8'h80;
				feed_byte(CHR_BSLASH);
				feed_byte(b);
				return;
			end else begin
				feed_byte(CHR_BSLASH);
				feed_byte(CHR_LC_U);
				repeat ($urandom_range(0, 3)) feed_byte(hex_char(4'($urandom_range(0, 15))));
				b = 8'($urandom_range(0, 255));
				if (b inside {[CHR_DIG_0:CHR_DIG_9], [CHR_LC_A:CHR_LC_F], [CHR_UC_A:CHR_UC_F]})
					b ^= 8'h80;
				feed_byte(b);
				return;
			end
		end
		feed_byte(CHR_QUOTE);
	endtask

	initial begin
		int phase_goal;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_byte  = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whitespace and stray bytes while idle, byte extremes, long and short code points,
		// end of string, illegal escape, bad hex digit
		feed_chars(" \t\015\n");
		feed_byte(8'h00);
		feed_byte(CHR_QUOTE);
		feed_byte(8'h00);
		feed_byte(8'hff);
		feed_chars("\\uFffF\\u07a9\"\"\\q\"\\u1G");
		hold_until_drained();

		fed_items  = 0;
		phase_goal = 0;
		for (int p = 0; p < 5; p++) begin
			src_idle_pct   = src_idle_by_phase[p];
			sink_stall_pct = sink_stall_by_phase[p];
			phase_goal += 46;
			while (fed_items < phase_goal) feed_random_text();
			hold_until_drained();
		end

		in_valid <= 1'b0;
		@(posedge clk iff outstanding == 0);
		repeat (24) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
